// ===== sv/sync_frame_parser_crc16_macros.svh =====
// Assertion macros for the sync frame parser.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SYNC_FRAME_PARSER_CRC16_MACROS_SVH
`define SYNC_FRAME_PARSER_CRC16_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fsp_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte step for the frame parser.
// No dependencies; used by every module of the block.
package fsp_pkg;

    localparam int DATA_W      = 8;
    localparam int IDX_W       = 10;
    localparam int LEN_W       = 11;
    localparam int CFG_W       = 10;
    localparam int CRC_W       = 16;
    localparam int HEADER_BYTES = 7;
    localparam int SYNC_BYTES  = 3;
    localparam int CRC_BYTES   = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    localparam logic [DATA_W-1:0] SYNC0     = 8'hAA;
    localparam logic [DATA_W-1:0] SYNC1     = 8'h44;
    localparam logic [DATA_W-1:0] SYNC2     = 8'h18;
    localparam logic [DATA_W-1:0] BYTE_MASK = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;

    // Header byte positions
    localparam int POS_ID     = 3;
    localparam int POS_ID_INV = 4;
    localparam int POS_LEN_LO = 5;

    typedef enum logic [1:0] {
        CMD_FEED    = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_FRAME    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NONE     = 3'd5
    } status_e_t;

    typedef enum logic [0:0] {
        REG_MIN_PAYLOAD = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } cfg_reg_e_t;

    // Classified command as it travels through the queue
    typedef struct packed {
        cmd_e_t             cmd;
        logic [DATA_W-1:0]  data;
        logic [IDX_W-1:0]   read_index;
        logic               rd_ok;
        logic [SYNC_BYTES-1:0] sync_hits;
    } q_item_t;

    // One result beat
    typedef struct packed {
        status_e_t         status;
        logic              rd_sel;
        logic [LEN_W-1:0]  flen;
    } res_t;

    // One byte of CRC-16/XMODEM, MSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < DATA_W; i++)
        begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/fsp_front.sv =====
// Front end of the frame parser: decodes the command and classifies the byte.
// Depends on fsp_pkg.
module fsp_front
    import fsp_pkg::*;
#(
    parameter int FRAME_BYTES = 1024
)
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [17:8] read_index, [23:18] zero
    output logic        push_valid,
    input  logic        push_ready,
    output q_item_t     push_item
);

    logic [DATA_W-1:0] data_byte;
    logic [IDX_W-1:0]  read_index;

    assign data_byte  = s_tdata[DATA_W-1:0];
    assign read_index = s_tdata[DATA_W+IDX_W-1:DATA_W];

    // Classify the beat and hand it to the queue
    always_comb
    begin
        push_item.cmd          = cmd_e_t'(s_tuser);
        push_item.data         = data_byte;
        push_item.read_index   = read_index;
        push_item.rd_ok        = (32'(read_index) < FRAME_BYTES);
        push_item.sync_hits[0] = (data_byte == SYNC0);
        push_item.sync_hits[1] = (data_byte == SYNC1);
        push_item.sync_hits[2] = (data_byte == SYNC2);
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ===== sv/fsp_queue.sv =====
// Short command queue between the front and back of the frame parser.
// Depends on fsp_pkg.
module fsp_queue
    import fsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_item_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_item_t pop_item
);

    q_item_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    fill_reg;
    logic             push;
    logic             pop;

    assign push_ready = (fill_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/fsp_back.sv =====
// Back end of the frame parser: sync hunt, header check, CRC, frame store and result register.
// Depends on fsp_pkg.
module fsp_back
    import fsp_pkg::*;
#(
    parameter int FRAME_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  q_item_t           item,
    input  logic [CFG_W-1:0]  min_payload,
    input  logic [CFG_W-1:0]  max_payload,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              res,
    output logic [DATA_W-1:0] read_data
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int TW = (CW > LEN_W) ? CW : LEN_W;
    localparam int AW = $clog2(FRAME_BYTES);

    logic [DATA_W-1:0] store_mem [FRAME_BYTES];

    logic [TW-1:0]     cnt_reg, cnt_next;
    logic [TW-1:0]     exp_reg, exp_next;
    logic              held_reg, held_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [DATA_W-1:0] id_reg, id_next;
    logic              inv_ok_reg, inv_ok_next;
    logic [DATA_W-1:0] len_lo_reg, len_lo_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic              out_valid_reg;
    res_t              res_reg;
    logic [DATA_W-1:0] rd_q_reg;

    logic              exec;
    logic              we;
    logic [AW-1:0]     wa;
    logic              re;
    logic [AW-1:0]     ra;
    status_e_t         status;
    logic [TW-1:0]     flen_full;
    logic              sync_hit;
    logic [15:0]       payload;
    logic [CRC_W-1:0]  rx_crc;
    logic              clear;

    assign pop_ready = !out_valid_reg || out_ready;
    assign exec      = pop_valid && pop_ready;
    assign ra        = AW'(item.read_index);

    // Execute one command against the parser state
    always_comb
    begin
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        held_next   = held_reg;
        crc_next    = crc_reg;
        id_next     = id_reg;
        inv_ok_next = inv_ok_reg;
        len_lo_next = len_lo_reg;
        last_next   = last_reg;
        we          = 1'b0;
        wa          = AW'(cnt_reg);
        re          = 1'b0;
        status      = ST_MORE;
        clear       = 1'b0;
        sync_hit    = item.sync_hits[cnt_reg[1:0]];
        payload     = {item.data, len_lo_reg};
        rx_crc      = {item.data, last_reg};

        unique case (item.cmd)
            CMD_FEED:
            begin
                if (held_reg)
                begin
                    status = ST_INVALID;
                end
                else if (cnt_reg < TW'(SYNC_BYTES))
                begin
                    // Hunt for the sync; a stray AA restarts as the first sync byte
                    if (sync_hit)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (item.sync_hits[0])
                    begin
                        we       = 1'b1;
                        wa       = '0;
                        cnt_next = TW'(1);
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                end
                else if (cnt_reg >= TW'(FRAME_BYTES))
                begin
                    clear  = 1'b1;
                    status = ST_OVERFLOW;
                end
                else
                begin
                    we        = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    last_next = item.data;
                    // Run the CRC over payload bytes only
                    if (exp_reg != '0 && cnt_reg >= TW'(HEADER_BYTES)
                        && (cnt_reg + TW'(CRC_BYTES)) < exp_reg)
                        crc_next = crc16_byte(crc_reg, item.data);
                    if (cnt_reg == TW'(POS_ID))
                        id_next = item.data;
                    if (cnt_reg == TW'(POS_ID_INV))
                        inv_ok_next = (item.data == (id_reg ^ BYTE_MASK));
                    if (cnt_reg == TW'(POS_LEN_LO))
                        len_lo_next = item.data;

                    if (cnt_next == TW'(HEADER_BYTES))
                    begin
                        // Check id complement and payload limits
                        if (!inv_ok_reg || payload < 16'(min_payload)
                            || payload > 16'(max_payload))
                        begin
                            clear  = 1'b1;
                            status = ST_INVALID;
                        end
                        else
                        begin
                            exp_next = TW'(payload[CFG_W-1:0]) + TW'(HEADER_BYTES + CRC_BYTES);
                            crc_next = '0;
                        end
                    end
                    else if (exp_reg != '0 && cnt_next == exp_reg)
                    begin
                        // Compare the received little-endian CRC
                        if (crc_reg != rx_crc)
                        begin
                            clear  = 1'b1;
                            status = ST_INVALID;
                        end
                        else
                        begin
                            held_next = 1'b1;
                            status    = ST_FRAME;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                clear = 1'b1;
            end
            CMD_READ:
            begin
                re = item.rd_ok;
            end
            CMD_RELEASE:
            begin
                if (held_reg)
                begin
                    status = ST_RELEASED;
                    clear  = 1'b1;
                end
                else
                begin
                    status = ST_NONE;
                end
            end
            default:
            begin
                status = ST_MORE;
            end
        endcase

        if (item.cmd == CMD_RELEASE)
            flen_full = held_reg ? cnt_reg : '0;
        else if (clear)
            flen_full = '0;
        else
            flen_full = held_next ? cnt_next : '0;

        if (clear)
        begin
            cnt_next  = '0;
            exp_next  = '0;
            held_next = 1'b0;
            crc_next  = '0;
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            exp_reg       <= '0;
            held_reg      <= 1'b0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                cnt_reg  <= cnt_next;
                exp_reg  <= exp_next;
                held_reg <= held_next;
                crc_reg  <= crc_next;
            end
            if (exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Header bytes and the result payload
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            id_reg         <= id_next;
            inv_ok_reg     <= inv_ok_next;
            len_lo_reg     <= len_lo_next;
            last_reg       <= last_next;
            res_reg.status <= status;
            res_reg.rd_sel <= re;
            res_reg.flen   <= LEN_W'(flen_full);
        end
    end

    // Frame store: one write or one registered read per command
    always_ff @(posedge clk)
    begin
        if (exec && we)
            store_mem[wa] <= item.data;
        if (exec && re)
            rd_q_reg <= store_mem[ra];
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign read_data = res_reg.rd_sel ? rd_q_reg : '0;

endmodule

// ===== sv/sync_frame_parser_crc16.sv =====
// Top level of the sync frame parser: configuration registers, front, queue and back.
// Depends on fsp_pkg, fsp_front, fsp_queue, fsp_back and the assertion macro header.
//
// Byte-serial frame parser. Feed bytes (func 0) are matched against the sync AA 44 18,
// then a frame id, its complement and a little-endian payload length that must lie in
// [min_payload, max_payload], then the payload and its little-endian CRC-16/XMODEM.
// A good frame is held and further feeds return invalid until a release (func 3) or a
// timeout clear (func 1); func 2 reads a stored byte by index. Every input beat gives
// exactly one result beat. The block takes one beat per cycle unless the queue or the output
// stalls: the back end executes each command with one access to the single-port frame store
// and a one-byte CRC step, and a result passes through a queue slot and the result register.
// A four-entry queue and the output register let input and output stall independently.
// Configuration writes are taken at any time but belong to idle periods.
`include "sync_frame_parser_crc16_macros.svh"

module sync_frame_parser_crc16
    import fsp_pkg::*;
#(
    parameter int FRAME_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] func
    input  logic [23:0] s_tdata,    // [7:0] data_byte, [17:8] read_index, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,    // [2:0] status
    output logic [23:0] m_tdata,    // [7:0] read_data, [18:8] frame_length, [23:19] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [CFG_W-1:0]  min_payload_reg;
    logic [CFG_W-1:0]  max_payload_reg;
    logic              push_valid;
    logic              push_ready;
    q_item_t           push_item;
    logic              pop_valid;
    logic              pop_ready;
    q_item_t           pop_item;
    res_t              res;
    logic [DATA_W-1:0] read_data;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_payload_reg <= 10'd1;
            max_payload_reg <= 10'd1015;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e_t'(cfg_index))
                REG_MIN_PAYLOAD: min_payload_reg <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         min_payload_reg <= min_payload_reg;
            endcase
        end
    end

    fsp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fsp_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .item        (pop_item),
        .min_payload (min_payload_reg),
        .max_payload (max_payload_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .res         (res),
        .read_data   (read_data)
    );

    // Pack the result beat
    assign m_tuser = res.status;
    assign m_tdata = {5'b0, res.flen, read_data};

    // A completed or released frame always reports its length
    `FSP_ASSERT_IMPL(a_frame_len, m_tvalid && (m_tuser == ST_FRAME || m_tuser == ST_RELEASED), m_tdata[18:8] != 11'd0, "held frame reported with zero length")
    // Only a read returns data, and only with status more
    `FSP_ASSERT_IMPL(a_rd_status, m_tvalid && m_tuser != ST_MORE, m_tdata[7:0] == 8'd0, "read data on a non-read result")
    // Nothing-held results carry no length
    `FSP_ASSERT_IMPL(a_none_len, m_tvalid && m_tuser == ST_NONE, m_tdata[18:8] == 11'd0, "length reported with nothing held")
    // A beat pushed into the queue is available to the back end next cycle
    `FSP_ASSERT_NEXT(a_queue_fill, push_valid && push_ready, pop_valid, "queue lost a pushed beat")

endmodule

// ===== verif/sync_frame_parser_crc16_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sync_frame_parser_crc16: directed frames, limit corners,
// then random frame traffic with random stalls on both streams. Depends on fsp_pkg.
module sync_frame_parser_crc16_tb;
    import fsp_pkg::*;

    localparam int STORE_BYTES = 1024;
    localparam int MAX_GAP     = 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BEATS = 550;

    // Ways a generated frame can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CRC,
        FLAW_BAD_INV,
        FLAW_TRUNCATE
    } frame_flaw_t;

    typedef struct packed {
        status_e_t          status;
        logic [DATA_W-1:0]  rd;
        logic [LEN_W-1:0]   flen;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = CMD_FEED;    // [1:0] func
    logic [23:0] s_tdata = '0;          // [7:0] data_byte, [17:8] read_index, [23:18] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;               // [2:0] status
    logic [23:0] m_tdata;               // [7:0] read_data, [18:8] frame_length, [23:19] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_MIN_PAYLOAD;
    logic [9:0]  cfg_data = '0;

    // Shadow copy of the parser state
    logic [DATA_W-1:0] shadow_store [STORE_BYTES];
    int                store_hi = 0;
    int                shadow_count = 0;
    int                shadow_total = 0;
    bit                shadow_held = 1'b0;
    logic [CRC_W-1:0]  shadow_crc = '0;
    int                lim_min = 1;
    int                lim_max = 1015;

    parse_result_t expected_results [$];
    parse_result_t head_result;
    int            errors = 0;
    int            beats_sent = 0;
    int            cycle_count = 0;
    bit            idle_on = 1'b1;

    sync_frame_parser_crc16 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // CRC-16/XMODEM over one byte, MSB first
    function automatic logic [CRC_W-1:0] xmodem_next(input logic [CRC_W-1:0] crc,
                                                     input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[CRC_W-1] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    function automatic void parser_clear();
        shadow_count = 0;
        shadow_total = 0;
        shadow_held  = 1'b0;
        shadow_crc   = '0;
    endfunction

    function automatic void store_byte(input int pos, input logic [DATA_W-1:0] b);
        shadow_store[pos] = b;
        if (pos + 1 > store_hi)
        begin
            store_hi = pos + 1;
        end
    endfunction

    function automatic status_e_t feed_step(input logic [DATA_W-1:0] b);
        int                pos;
        int                plen;
        logic [DATA_W-1:0] want;
        logic [CRC_W-1:0]  rx_crc;
        if (shadow_held)
        begin
            return ST_INVALID;
        end
        // Sync hunt: a stray AA restarts as the first sync byte
        if (shadow_count < SYNC_BYTES)
        begin
            want = (shadow_count == 0) ? SYNC0 : (shadow_count == 1) ? SYNC1 : SYNC2;
            if (b == want)
            begin
                store_byte(shadow_count, b);
                shadow_count++;
            end
            else if (b == SYNC0)
            begin
                store_byte(0, b);
                shadow_count = 1;
            end
            else
            begin
                shadow_count = 0;
            end
            return ST_MORE;
        end
        if (shadow_count >= STORE_BYTES)
        begin
            parser_clear();
            return ST_OVERFLOW;
        end
        pos = shadow_count;
        store_byte(pos, b);
        shadow_count++;
        if (shadow_total != 0 && pos >= HEADER_BYTES && pos + 2 < shadow_total)
        begin
            shadow_crc = xmodem_next(shadow_crc, b);
        end
        // Header complete: check complement and length window
        if (shadow_count == HEADER_BYTES)
        begin
            plen = {shadow_store[POS_LEN_LO + 1], shadow_store[POS_LEN_LO]};
            if (shadow_store[POS_ID_INV] != (shadow_store[POS_ID] ^ BYTE_MASK)
                || plen < lim_min || plen > lim_max)
            begin
                parser_clear();
                return ST_INVALID;
            end
            shadow_total = HEADER_BYTES + plen + CRC_BYTES;
            shadow_crc = '0;
        end
        // Last CRC byte in: compare with the running CRC
        if (shadow_total != 0 && shadow_count == shadow_total)
        begin
            rx_crc = {shadow_store[shadow_total - 1], shadow_store[shadow_total - 2]};
            if (shadow_crc != rx_crc)
            begin
                parser_clear();
                return ST_INVALID;
            end
            shadow_held = 1'b1;
            return ST_FRAME;
        end
        return ST_MORE;
    endfunction

    function automatic parse_result_t parser_step(input cmd_e_t func,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [IDX_W-1:0] idx);
        parse_result_t r;
        r.status = ST_MORE;
        r.rd = '0;
        r.flen = '0;
        case (func)
            CMD_FEED:  r.status = feed_step(b);
            CMD_CLEAR: parser_clear();
            CMD_READ:  r.rd = shadow_store[idx];
            default:   ;
        endcase
        if (func == CMD_RELEASE)
        begin
            if (shadow_held)
            begin
                r.status = ST_RELEASED;
                r.flen = LEN_W'(shadow_count);
                parser_clear();
            end
            else
            begin
                r.status = ST_NONE;
            end
        end
        else
        begin
            r.flen = shadow_held ? LEN_W'(shadow_count) : '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one beat; valid stays high after acceptance so back-to-back beats need no dip
    task automatic put_beat(input cmd_e_t func, input logic [DATA_W-1:0] b,
                            input logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, idx, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(parser_step(func, b, idx));
        beats_sent++;
    endtask

    task automatic feed(input logic [DATA_W-1:0] b);
        put_beat(CMD_FEED, b, IDX_W'($urandom));
    endtask

    task automatic issue(input cmd_e_t func);
        put_beat(func, DATA_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic read_at(input int idx);
        put_beat(CMD_READ, DATA_W'($urandom), IDX_W'(idx));
    endtask

    // Drop valid and wait until every expected beat is back, then some slack
    task automatic settle(input int slack);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (slack) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e_t r, input logic [CFG_W-1:0] v);
        settle(4);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (r == REG_MIN_PAYLOAD)
        begin
            lim_min = v;
        end
        else
        begin
            lim_max = v;
        end
    endtask

    task automatic set_limits(input int lo, input int hi);
        write_reg(REG_MIN_PAYLOAD, CFG_W'(lo));
        write_reg(REG_MAX_PAYLOAD, CFG_W'(hi));
    endtask

    // Build and send sync, header, payload and CRC with an optional flaw
    task automatic send_frame(input logic [7:0] id, input logic [15:0] len_field,
                              input int n_body, input frame_flaw_t flaw);
        logic [DATA_W-1:0] wire_bytes [$];
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] inv;
        logic [CRC_W-1:0]  crc;
        int                cut;
        crc = '0;
        inv = id ^ BYTE_MASK;
        if (flaw == FLAW_BAD_INV)
        begin
            inv = inv ^ (8'h01 << $urandom_range(0, 7));
        end
        wire_bytes = '{SYNC0, SYNC1, SYNC2, id, inv, len_field[7:0], len_field[15:8]};
        for (int i = 0; i < n_body; i++)
        begin
            b = DATA_W'($urandom);
            crc = xmodem_next(crc, b);
            wire_bytes.push_back(b);
        end
        if (flaw == FLAW_BAD_CRC)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        wire_bytes.push_back(crc[7:0]);
        wire_bytes.push_back(crc[15:8]);
        cut = (flaw == FLAW_TRUNCATE) ? $urandom_range(1, wire_bytes.size() - 1)
                                      : wire_bytes.size();
        for (int i = 0; i < cut; i++)
        begin
            feed(wire_bytes[i]);
        end
        if (flaw == FLAW_TRUNCATE)
        begin
            issue(CMD_CLEAR);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_idle_commands();
        issue(CMD_RELEASE);
        issue(CMD_CLEAR);
        feed(8'h00);
        feed(8'hFF);
        issue(CMD_RELEASE);
    endtask

    task automatic test_sync_hunt();
        // Repeated AA stays the first sync byte; other mismatches restart
        feed(SYNC0);
        feed(SYNC0);
        feed(SYNC1);
        feed(SYNC0);
        feed(SYNC1);
        feed(8'h55);
        feed(SYNC0);
        feed(SYNC1);
        feed(SYNC2);
        issue(CMD_CLEAR);
        read_at(0);
        read_at(2);
    endtask

    task automatic test_good_frame();
        send_frame(8'h5A, 16'd1, 1, FLAW_NONE);
        feed(SYNC0);
        read_at(3);
        read_at(9);
        issue(CMD_RELEASE);
        issue(CMD_RELEASE);
        // A held frame is also dropped by a timeout clear
        send_frame(8'hC3, 16'd4, 4, FLAW_NONE);
        issue(CMD_CLEAR);
        issue(CMD_RELEASE);
    endtask

    task automatic test_header_errors();
        send_frame(8'h11, 16'd2, 2, FLAW_BAD_INV);
        send_frame(8'h22, 16'd0, 0, FLAW_NONE);
        send_frame(8'h33, 16'd1016, 2, FLAW_NONE);
        send_frame(8'hFF, 16'hFFFF, 0, FLAW_NONE);
    endtask

    task automatic test_crc_error();
        send_frame(8'h00, 16'd3, 3, FLAW_BAD_CRC);
        send_frame(8'h81, 16'd2, 2, FLAW_TRUNCATE);
    endtask

    task automatic test_limit_corners();
        // Empty payload allowed only when the minimum limit is zero
        set_limits(0, 0);
        send_frame(8'h7E, 16'd0, 0, FLAW_NONE);
        issue(CMD_RELEASE);
        send_frame(8'h7E, 16'd1, 1, FLAW_NONE);
        // Inverted window rejects every header
        set_limits(1023, 0);
        send_frame(8'h01, 16'd0, 0, FLAW_NONE);
        send_frame(8'h02, 16'd5, 5, FLAW_NONE);
        // Largest frame that fits the store
        set_limits(1015, 1015);
        send_frame(8'hA5, 16'd1015, 1015, FLAW_NONE);
        read_at(STORE_BYTES - 1);
        read_at(512);
        read_at(682);
        issue(CMD_RELEASE);
        // A length past the store fills it and overflows on the next byte
        set_limits(0, 1023);
        send_frame(8'h96, 16'd1016, 1016, FLAW_NONE);
        read_at(341);
        read_at(1023);
        issue(CMD_RELEASE);
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        int hi;
        int plen;
        int lo_len;
        logic [15:0] bad_len;
        cmd_e_t func;
        start = beats_sent;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_limits(0, 40);
                1: set_limits($urandom_range(0, 6), $urandom_range(8, 40));
                2: set_limits(30, 3);
                3: set_limits(1, 1015);
                default: set_limits(0, 1023);
            endcase
            while (beats_sent - start < (phase + 1) * RANDOM_BEATS / 5)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    idle_on = ~idle_on;
                end
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    // Start a frame from a clean parser most of the time
                    if (shadow_held && $urandom_range(0, 4) != 0)
                    begin
                        issue(CMD_RELEASE);
                    end
                    else if (!shadow_held && shadow_count != 0)
                    begin
                        issue(CMD_CLEAR);
                    end
                    if ($urandom_range(0, 7) == 0)
                    begin
                        feed(SYNC0);
                    end
                    if (lim_min <= lim_max)
                    begin
                        hi = (lim_max < lim_min + 24) ? lim_max : lim_min + 24;
                        plen = $urandom_range(lim_min, hi);
                    end
                    else
                    begin
                        plen = $urandom_range(0, 24);
                    end
                end
                if (pick < 60)
                begin
                    send_frame(8'($urandom), 16'(plen), plen, FLAW_NONE);
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                    begin
                        issue(CMD_RELEASE);
                    end
                    else if (pick < 17)
                    begin
                        issue(CMD_CLEAR);
                    end
                end
                else if (pick < 70)
                begin
                    send_frame(8'($urandom), 16'(plen), plen, FLAW_BAD_CRC);
                end
                else if (pick < 75)
                begin
                    send_frame(8'($urandom), 16'(plen), plen, FLAW_BAD_INV);
                end
                else if (pick < 80)
                begin
                    // Length outside the window, header then a few stray bytes
                    lo_len = (lim_min > 0) ? $urandom_range(0, lim_min - 1) : 0;
                    if (lim_max < 1023 && $urandom_range(0, 1) == 0)
                    begin
                        bad_len = 16'(lim_max + 1 + $urandom_range(0, 5));
                    end
                    else if (lim_min > 0 && $urandom_range(0, 1) == 0)
                    begin
                        bad_len = 16'(lo_len);
                    end
                    else
                    begin
                        bad_len = 16'h0400 | 16'($urandom);
                    end
                    send_frame(8'($urandom), bad_len, $urandom_range(0, 4), FLAW_NONE);
                end
                else if (pick < 85)
                begin
                    send_frame(8'($urandom), 16'(plen), plen, FLAW_TRUNCATE);
                end
                else
                begin
                    // Noise: any command, stray bytes, reads of written entries
                    func = cmd_e_t'($urandom_range(0, 3));
                    if (func == CMD_READ)
                    begin
                        if (store_hi > 0)
                        begin
                            read_at($urandom_range(0, store_hi - 1));
                        end
                        else
                        begin
                            issue(CMD_RELEASE);
                        end
                    end
                    else if (func == CMD_FEED)
                    begin
                        feed(($urandom_range(0, 3) == 0) ? SYNC0 : DATA_W'($urandom));
                    end
                    else
                    begin
                        issue(func);
                    end
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, then compare each beat in order
    // ------------------------------------------------------------------

    initial
    begin
        int gap;
        forever
        begin
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d", m_tuser);
                errors++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                if (m_tuser !== head_result.status)
                begin
                    $error("status expected %0d actual %0d", head_result.status, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== head_result.rd)
                begin
                    $error("read_data expected %0d actual %0d", head_result.rd, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[18:8] !== head_result.flen)
                begin
                    $error("frame_length expected %0d actual %0d",
                           head_result.flen, m_tdata[18:8]);
                    errors++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sync_frame_parser_crc16 test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_commands();
        test_sync_hunt();
        idle_on = 1'b0;
        test_good_frame();
        idle_on = 1'b1;
        test_header_errors();
        test_crc_error();
        test_limit_corners();
        test_random_traffic();
        settle(10);
        if (errors == 0)
        begin
            $display("sync_frame_parser_crc16 test passed");
        end
        else
        begin
            $display("sync_frame_parser_crc16 test failed");
        end
        $finish;
    end

endmodule

// ===== sync_frame_parser_crc16.f =====
+incdir+sv
sv/fsp_pkg.sv
sv/fsp_front.sv
sv/fsp_queue.sv
sv/fsp_back.sv
sv/sync_frame_parser_crc16.sv
verif/sync_frame_parser_crc16_tb.sv
